FILE: hdl/assert_macros.svh
// Assertion macros shared by the letterbox scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LBS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBS_ASSERT(lbl, clk, rst, prop, msg)
`define LBS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/lbs_pkg.sv
// Types, constants and the shared division step of the letterbox scaler.
package lbs_pkg;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int PROD_W  = 25;
   localparam int NUM_W   = 26;
   localparam int IDX_W   = 26;
   localparam int DATA_W  = 32;
   localparam int CSR_W   = 2;
   localparam int INDEX_W = 20;
   localparam int CHAN_W  = 8;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] dst_w;
      logic [DIM_W-1:0] dst_h;
      logic [DIM_W-1:0] rect_w;
      logic [DIM_W-1:0] rect_h;
      logic [DIM_W-1:0] off_x;
      logic [DIM_W-1:0] off_y;
      logic             empty;
      logic             ready;
   } geo_type;

   typedef struct packed {
      logic [DIM_W-1:0] rem;
      logic [DIM_W-1:0] low;
      logic [DIM_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic              border;
      logic              oob;
      logic [DATA_W-1:0] data;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PROD_W-1:0] nx;
      logic [PROD_W-1:0] ny;
      div_type           dx;
      div_type           dy;
      logic [DIM_W-1:0]  sx;
      logic [DIM_W-1:0]  sy;
      logic [IDX_W-1:0]  idx;
   } pipe_type;

   // The quotient must fit in DIM_W bits, so the upper half starts below the divisor.
   function automatic div_type div_init(logic [NUM_W-1:0] num);
      div_type r;
      r.rem = num[NUM_W-1:DIM_W];
      r.low = num[DIM_W-1:0];
      r.quo = '0;
      return r;
   endfunction

   function automatic div_type div_steps(div_type s, logic [DIM_W-1:0] dvs, int cnt);
      div_type r;
      logic [DIM_W:0] t;
      r = s;
      for (int i = 0; i < cnt; i++) begin
         t = {r.rem, r.low[DIM_W-1]};
         r.low = {r.low[DIM_W-2:0], 1'b0};
         if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            r.quo = {r.quo[DIM_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[DIM_W-2:0], 1'b0};
         end
         r.rem = t[DIM_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/lbs_if.sv
// Channel interfaces of the letterbox scaler: request, response and register write.
interface lbs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [lbs_pkg::INDEX_W-1:0] pixel_index;
   logic [lbs_pkg::DATA_W-1:0]  pixel_bgra;
   logic [lbs_pkg::COORD_W-1:0] dst_x;
   logic [lbs_pkg::COORD_W-1:0] dst_y;
   modport source (output valid, opcode, pixel_index, pixel_bgra, dst_x, dst_y, input ready);
   modport sink (input valid, opcode, pixel_index, pixel_bgra, dst_x, dst_y, output ready);
endinterface

interface lbs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lbs_pkg::CHAN_W-1:0] red;
   logic [lbs_pkg::CHAN_W-1:0] green;
   logic [lbs_pkg::CHAN_W-1:0] blue;
   logic [lbs_pkg::CHAN_W-1:0] alpha;
   logic                       inside_image;
   modport source (output valid, red, green, blue, alpha, inside_image, input ready);
   modport sink (input valid, red, green, blue, alpha, inside_image, output ready);
endinterface

interface lbs_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lbs_pkg::CSR_W-1:0] index;
   logic [lbs_pkg::DIM_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/letterbox_nearest_scaler_core.sv
// Top level of the letterbox nearest-neighbor scaler: render pipeline and frame store.
`include "assert_macros.svh"

// The core accepts one item per clock while rsp_ch does not stall and the fit is
// ready; render results pass the pipeline registers. Write items update the frame
// store at the same pipeline stage where renders read it, so items take effect in
// order. The two coordinate divisions run in a pipelined long divider over three
// stages, and the frame store is one single-port RAM with registered read. After
// reset and after every register write the fit rectangle is recomputed by a serial
// divider, during which req_ch.ready stays low. The frame store is not cleared:
// entries read before they are written return undefined data.
module letterbox_nearest_scaler_core #(
   parameter int SRC_PIXELS = 1048576,
   parameter int MAX_DIM    = 4096
) (
   input logic     clock,
   input logic     reset,
   lbs_req_if.sink   req_ch,
   lbs_rsp_if.source rsp_ch,
   lbs_csr_if.sink   csr_ch
);

   localparam int ADDR_W = $clog2(SRC_PIXELS);
   localparam int NSTG   = 9;
   localparam logic [lbs_pkg::IDX_W-1:0] STORE_END = lbs_pkg::IDX_W'(SRC_PIXELS);

   lbs_pkg::geo_type             geo;
   lbs_pkg::pipe_type            pipe_ff [NSTG];
   lbs_pkg::pipe_type            pipe_in [NSTG];
   logic                         adv, accept;
   logic                         out_v_ff, out_border_ff, out_oob_ff;
   logic [lbs_pkg::DATA_W-1:0]   rdata;
   logic                         ram_we;

   lbs_geometry #(.MAX_DIM(MAX_DIM)) u_geometry (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .geo    (geo)
   );

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv && geo.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      logic [lbs_pkg::DIM_W-1:0] xe, ye;
      logic [lbs_pkg::IDX_W-1:0] idx_sum;

      pipe_in[0]       = '0;
      pipe_in[0].valid = accept;
      pipe_in[0].op    = lbs_pkg::op_type'(req_ch.opcode);
      pipe_in[0].data  = req_ch.pixel_bgra;
      pipe_in[0].x     = req_ch.dst_x;
      pipe_in[0].y     = req_ch.dst_y;
      pipe_in[0].idx   = lbs_pkg::IDX_W'(req_ch.pixel_index);

      xe = {1'b0, pipe_ff[0].x};
      ye = {1'b0, pipe_ff[0].y};
      pipe_in[1] = pipe_ff[0];
      if (pipe_ff[0].op == lbs_pkg::OP_RENDER) begin
         if (xe >= geo.dst_w || ye >= geo.dst_h) begin
            pipe_in[1].valid = 1'b0;
         end
         pipe_in[1].border = geo.empty || xe < geo.off_x || ye < geo.off_y ||
            {1'b0, xe} >= {1'b0, geo.off_x} + {1'b0, geo.rect_w} ||
            {1'b0, ye} >= {1'b0, geo.off_y} + {1'b0, geo.rect_h};
         pipe_in[1].x = lbs_pkg::COORD_W'(xe - geo.off_x);
         pipe_in[1].y = lbs_pkg::COORD_W'(ye - geo.off_y);
      end

      pipe_in[2]    = pipe_ff[1];
      pipe_in[2].nx = lbs_pkg::PROD_W'(pipe_ff[1].x) * lbs_pkg::PROD_W'(geo.src_w);
      pipe_in[2].ny = lbs_pkg::PROD_W'(pipe_ff[1].y) * lbs_pkg::PROD_W'(geo.src_h);

      pipe_in[3]    = pipe_ff[2];
      pipe_in[3].dx = lbs_pkg::div_steps(
         lbs_pkg::div_init(lbs_pkg::NUM_W'(pipe_ff[2].nx)), geo.rect_w, 5);
      pipe_in[3].dy = lbs_pkg::div_steps(
         lbs_pkg::div_init(lbs_pkg::NUM_W'(pipe_ff[2].ny)), geo.rect_h, 5);

      pipe_in[4]    = pipe_ff[3];
      pipe_in[4].dx = lbs_pkg::div_steps(pipe_ff[3].dx, geo.rect_w, 4);
      pipe_in[4].dy = lbs_pkg::div_steps(pipe_ff[3].dy, geo.rect_h, 4);

      pipe_in[5]    = pipe_ff[4];
      pipe_in[5].dx = lbs_pkg::div_steps(pipe_ff[4].dx, geo.rect_w, 4);
      pipe_in[5].dy = lbs_pkg::div_steps(pipe_ff[4].dy, geo.rect_h, 4);

      pipe_in[6]    = pipe_ff[5];
      pipe_in[6].sx = (pipe_ff[5].dx.quo >= geo.src_w) ? geo.src_w - 13'd1
                                                      : pipe_ff[5].dx.quo;
      pipe_in[6].sy = (pipe_ff[5].dy.quo >= geo.src_h) ? geo.src_h - 13'd1
                                                      : pipe_ff[5].dy.quo;

      pipe_in[7] = pipe_ff[6];
      if (pipe_ff[6].op == lbs_pkg::OP_RENDER) begin
         pipe_in[7].idx = lbs_pkg::IDX_W'(pipe_ff[6].sy) * lbs_pkg::IDX_W'(geo.src_w);
      end

      idx_sum = pipe_ff[7].idx;
      if (pipe_ff[7].op == lbs_pkg::OP_RENDER) begin
         idx_sum = pipe_ff[7].idx + lbs_pkg::IDX_W'(pipe_ff[7].sx);
      end
      pipe_in[8]     = pipe_ff[7];
      pipe_in[8].idx = idx_sum;
      pipe_in[8].oob = idx_sum >= STORE_END;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NSTG; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         out_v_ff      <= pipe_ff[NSTG-1].valid && pipe_ff[NSTG-1].op == lbs_pkg::OP_RENDER;
         out_border_ff <= pipe_ff[NSTG-1].border;
         out_oob_ff    <= pipe_ff[NSTG-1].oob;
      end
   end

   assign ram_we = pipe_ff[NSTG-1].valid && pipe_ff[NSTG-1].op == lbs_pkg::OP_WRITE &&
                   !pipe_ff[NSTG-1].oob;

   lbs_ram #(.WIDTH(lbs_pkg::DATA_W), .DEPTH(SRC_PIXELS)) u_frame_store (
      .clock (clock),
      .en    (adv),
      .we    (ram_we),
      .addr  (pipe_ff[NSTG-1].idx[ADDR_W-1:0]),
      .wdata (pipe_ff[NSTG-1].data),
      .rdata (rdata)
   );

   always_comb begin
      rsp_ch.valid        = out_v_ff;
      rsp_ch.inside_image = !out_border_ff;
      if (out_border_ff) begin
         rsp_ch.red   = '0;
         rsp_ch.green = '0;
         rsp_ch.blue  = '0;
         rsp_ch.alpha = 8'hFF;
      end else if (out_oob_ff) begin
         rsp_ch.red   = '0;
         rsp_ch.green = '0;
         rsp_ch.blue  = '0;
         rsp_ch.alpha = '0;
      end else begin
         rsp_ch.red   = rdata[23:16];
         rsp_ch.green = rdata[15:8];
         rsp_ch.blue  = rdata[7:0];
         rsp_ch.alpha = rdata[31:24];
      end
   end

   `LBS_ASSERT(a_stall_holds_pipe, clock, reset, out_v_ff && !rsp_ch.ready |=> $stable(pipe_ff[0]), "pipeline moved during a stall")
   `LBS_ASSERT(a_rsp_from_pipe, clock, reset, $rose(out_v_ff) |-> $past(pipe_ff[NSTG-1].valid), "result without an item in the last stage")
   `LBS_ASSERT(a_accept_needs_fit, clock, reset, accept |-> geo.ready && !$past(csr_ch.valid), "item accepted while the fit is recomputed")
   `LBS_ASSERT_NR(a_reset_clears_rsp, clock, reset |=> !out_v_ff, "result valid after reset")

endmodule

FILE: hdl/lbs_ram.sv
// Generic single-port RAM with registered read data.
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/lbs_geometry.sv
// Dimension registers and the serial computation of the centered fit rectangle.
module lbs_geometry #(
   parameter int MAX_DIM = 4096
) (
   input  logic             clock,
   input  logic             reset,
   lbs_csr_if.sink          csr_ch,
   output lbs_pkg::geo_type geo
);

   typedef enum logic [2:0] {G_MUL, G_SEL, G_DIV, G_DONE, G_IDLE} state_type;

   localparam logic [3:0] DIV_LAST = 4'(lbs_pkg::DIM_W - 1);

   state_type                  state_ff;
   logic [lbs_pkg::DIM_W-1:0]  src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [lbs_pkg::DIM_W-1:0]  sw_c, sh_c, dw_c, dh_c;
   logic [lbs_pkg::NUM_W-1:0]  pw_ff, ph_ff, num_sel;
   logic                       wide, wide_ff;
   lbs_pkg::div_type           div_ff;
   logic [lbs_pkg::DIM_W-1:0]  dvs_ff;
   logic [3:0]                 cnt_ff;
   logic [lbs_pkg::DIM_W-1:0]  rect_w_ff, rect_h_ff, off_x_ff, off_y_ff;
   logic                       empty_ff;

   function automatic logic [lbs_pkg::DIM_W-1:0] clamp_dim(logic [lbs_pkg::DIM_W-1:0] v);
      logic [lbs_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = lbs_pkg::DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = lbs_pkg::DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   always_comb begin
      sw_c    = clamp_dim(src_w_ff);
      sh_c    = clamp_dim(src_h_ff);
      dw_c    = clamp_dim(dst_w_ff);
      dh_c    = clamp_dim(dst_h_ff);
      wide    = pw_ff > ph_ff;
      num_sel = wide ? ph_ff : pw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_MUL;
         src_w_ff <= 13'd640;
         src_h_ff <= 13'd480;
         dst_w_ff <= 13'd640;
         dst_h_ff <= 13'd480;
      end else if (csr_ch.valid) begin
         unique case (lbs_pkg::csr_index_type'(csr_ch.index))
            lbs_pkg::CSR_SRC_WIDTH:  src_w_ff <= csr_ch.data;
            lbs_pkg::CSR_SRC_HEIGHT: src_h_ff <= csr_ch.data;
            lbs_pkg::CSR_DST_WIDTH:  dst_w_ff <= csr_ch.data;
            lbs_pkg::CSR_DST_HEIGHT: dst_h_ff <= csr_ch.data;
         endcase
         state_ff <= G_MUL;
      end else begin
         unique case (state_ff)
            G_MUL: begin
               pw_ff    <= lbs_pkg::NUM_W'(dw_c) * lbs_pkg::NUM_W'(sh_c);
               ph_ff    <= lbs_pkg::NUM_W'(dh_c) * lbs_pkg::NUM_W'(sw_c);
               state_ff <= G_SEL;
            end
            G_SEL: begin
               wide_ff  <= wide;
               div_ff   <= lbs_pkg::div_init(num_sel);
               dvs_ff   <= wide ? sh_c : sw_c;
               cnt_ff   <= '0;
               state_ff <= G_DIV;
            end
            G_DIV: begin
               div_ff <= lbs_pkg::div_steps(div_ff, dvs_ff, 1);
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= G_DONE;
               end
            end
            G_DONE: begin
               if (wide_ff) begin
                  rect_w_ff <= div_ff.quo;
                  rect_h_ff <= dh_c;
                  off_x_ff  <= (dw_c - div_ff.quo) >> 1;
                  off_y_ff  <= '0;
               end else begin
                  rect_w_ff <= dw_c;
                  rect_h_ff <= div_ff.quo;
                  off_x_ff  <= '0;
                  off_y_ff  <= (dh_c - div_ff.quo) >> 1;
               end
               empty_ff <= div_ff.quo == '0;
               state_ff <= G_IDLE;
            end
            G_IDLE: begin
            end
            default: state_ff <= G_MUL;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   always_comb begin
      geo.src_w  = sw_c;
      geo.src_h  = sh_c;
      geo.dst_w  = dw_c;
      geo.dst_h  = dh_c;
      geo.rect_w = rect_w_ff;
      geo.rect_h = rect_h_ff;
      geo.off_x  = off_x_ff;
      geo.off_y  = off_y_ff;
      geo.empty  = empty_ff;
      geo.ready  = state_ff == G_IDLE;
   end

endmodule
